### hw/rtl/service_location_message_parser_macros.svh
// ----------------------------------------------------------------------------
// slp parser assertion macros
// implication checks, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef SERVICE_LOCATION_MESSAGE_PARSER_MACROS_SVH
`define SERVICE_LOCATION_MESSAGE_PARSER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SLP_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
`define SLP_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`else
`define SLP_ASSERT_IMP(label, clk, rst_n, a, c)
`define SLP_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

### hw/rtl/slp_pkg.sv
// ----------------------------------------------------------------------------
// slp parser package
// phases, item kinds, field tags and the body program table
// ----------------------------------------------------------------------------
package slp_pkg;
	typedef enum logic [3:0] {
		PH_HDR = 4'd0, PH_LANG = 4'd1, PH_PFX = 4'd2, PH_STR = 4'd3,
		PH_ERR = 4'd4, PH_UCNT = 4'd5, PH_UFIX = 4'd6, PH_UPFX = 4'd7,
		PH_URL = 4'd8, PH_ACNT = 4'd9, PH_AHDR = 4'd10, PH_SPFX = 4'd11,
		PH_SPI = 4'd12, PH_ADATA = 4'd13, PH_TRAIL = 4'd14, PH_IGN = 4'd15
	} phase_t;

	typedef enum logic [2:0] {
		K_END = 3'd0, K_STR = 3'd1, K_ERR = 3'd2, K_UCNT = 3'd3,
		K_UENT = 3'd4, K_ACNT = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_VERSION = 2'd1, ST_PARSE = 2'd2
	} status_t;

	localparam logic [2:0] SLOT_SPI = 3'd4;
	localparam logic [2:0] SLOT_URL = 3'd5;
	localparam logic [7:0] SLP_VERSION = 8'd2;
	localparam logic [15:0] FLAG_MASK = 16'h1fff;
	localparam int unsigned MIN_LEN = 18;
	localparam logic [15:0] AUTH_MIN = 16'd10;

	typedef struct packed {
		kind_t kind;
		logic [2:0] slot;
	} item_t;

	// body program: one row per function, one item per step
	function automatic item_t body_item(input logic [2:0] fn, input logic [2:0] step);
		item_t it;
		it = '{kind: K_END, slot: 3'd0};
		case ({fn, step})
			{3'd1, 3'd0}: it = '{K_STR, 3'd0};
			{3'd1, 3'd1}: it = '{K_STR, 3'd1};
			{3'd1, 3'd2}: it = '{K_STR, 3'd2};
			{3'd1, 3'd3}: it = '{K_STR, 3'd3};
			{3'd1, 3'd4}: it = '{K_STR, 3'd4};
			{3'd2, 3'd0}: it = '{K_ERR, 3'd0};
			{3'd2, 3'd1}: it = '{K_UCNT, 3'd0};
			{3'd3, 3'd0}: it = '{K_UENT, 3'd0};
			{3'd3, 3'd1}: it = '{K_STR, 3'd1};
			{3'd3, 3'd2}: it = '{K_STR, 3'd2};
			{3'd3, 3'd3}: it = '{K_STR, 3'd6};
			{3'd3, 3'd4}: it = '{K_ACNT, 3'd0};
			{3'd4, 3'd0}: it = '{K_STR, 3'd2};
			{3'd4, 3'd1}: it = '{K_UENT, 3'd0};
			{3'd4, 3'd2}: it = '{K_STR, 3'd7};
			{3'd5, 3'd0}: it = '{K_ERR, 3'd0};
			{3'd6, 3'd0}: it = '{K_STR, 3'd0};
			{3'd6, 3'd1}: it = '{K_STR, 3'd5};
			{3'd6, 3'd2}: it = '{K_STR, 3'd2};
			{3'd6, 3'd3}: it = '{K_STR, 3'd7};
			{3'd6, 3'd4}: it = '{K_STR, 3'd4};
			{3'd7, 3'd0}: it = '{K_ERR, 3'd0};
			{3'd7, 3'd1}: it = '{K_STR, 3'd6};
			{3'd7, 3'd2}: it = '{K_ACNT, 3'd0};
			default: it = '{K_END, 3'd0};
		endcase
		return it;
	endfunction

	// field tag for each phase
	function automatic logic [3:0] phase_tag(input phase_t ph);
		logic [3:0] t;
		case (ph)
			PH_HDR: t = 4'd0;
			PH_LANG: t = 4'd1;
			PH_PFX, PH_UPFX, PH_SPFX: t = 4'd2;
			PH_STR, PH_URL: t = 4'd3;
			PH_ERR: t = 4'd9;
			PH_UCNT, PH_ACNT: t = 4'd4;
			PH_UFIX: t = 4'd5;
			PH_AHDR: t = 4'd6;
			PH_SPI: t = 4'd7;
			PH_ADATA: t = 4'd8;
			PH_TRAIL: t = 4'd10;
			default: t = 4'd11;
		endcase
		return t;
	endfunction
endpackage

### hw/rtl/service_location_message_parser.sv
// ----------------------------------------------------------------------------
// slp v2 datagram parser
// tags each datagram byte with its field and reports status on the last byte
// ----------------------------------------------------------------------------
// usage:
//   input channel: one datagram byte per word (data_byte, last_byte) under
//   valid / ready. output channel: one tag word per input word, with
//   field_tag, string_slot, offsets, indices, function_code, and on the
//   word for the last byte done_res and status.
//   latency: a result is offered the cycle after its byte is accepted.
//   throughput: one byte per cycle while out_ready is high; parser state
//   updates once per byte; the single output register refills as it drains.
//   stall: when out_ready is low the result holds and in_ready drops, so
//   no byte is lost; in_ready = !out_valid || out_ready.
//   reset: clears all parse state to the header phase, output empty.
//   after the last byte of a datagram the state returns to reset values.
// ----------------------------------------------------------------------------
`include "service_location_message_parser_macros.svh"
module service_location_message_parser #(
	parameter int LENGTH_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [7:0] data_byte,
	input  logic last_byte,
	output logic out_valid,
	input  logic out_ready,
	output logic [3:0] field_tag,
	output logic [2:0] string_slot,
	output logic [15:0] field_offset,
	output logic [15:0] entry_index,
	output logic [7:0] auth_index,
	output logic [7:0] function_code,
	output logic done_res,
	output logic [1:0] status
);
	import slp_pkg::*;

	localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
	localparam logic [LENGTH_BITS-1:0] LEN_MIN = LENGTH_BITS'(MIN_LEN);

	// parse state
	logic [LENGTH_BITS-1:0] byte_count_q, declared_length_q;
	phase_t phase_q;
	logic [15:0] remaining_q, position_q;
	logic [7:0] high_q, func_q;
	logic version_bad_q, error_q;
	logic [15:0] urls_left_q, url_num_q;
	logic [7:0] auths_left_q, auth_num_q;
	logic [15:0] auth_left_q;
	logic [2:0] step_q;

	logic [LENGTH_BITS-1:0] byte_count_d, declared_length_d;
	phase_t phase_d;
	logic [15:0] remaining_d, position_d;
	logic [7:0] high_d, func_d;
	logic version_bad_d, error_d;
	logic [15:0] urls_left_d, url_num_d;
	logic [7:0] auths_left_d, auth_num_d;
	logic [15:0] auth_left_d;
	logic [2:0] step_d;

	logic accept;
	assign in_ready = !out_valid || out_ready;
	assign accept = in_valid && in_ready;

	// result word of the current byte
	logic [2:0] slot_c;
	logic [1:0] status_c;
	item_t cur_item;
	assign cur_item = body_item(func_q[2:0], step_q);

	always_comb begin
		slot_c = 3'd0;
		if (phase_q == PH_PFX || phase_q == PH_STR) slot_c = cur_item.slot;
		else if (phase_q == PH_UPFX || phase_q == PH_URL) slot_c = SLOT_URL;
		else if (phase_q == PH_SPFX || phase_q == PH_SPI) slot_c = SLOT_SPI;
	end

	// next state for one byte
	always_comb begin
		logic [15:0] w16;
		logic [15:0] p;
		logic [LENGTH_BITS-1:0] dl;
		item_t nit;
		logic do_adv, do_start, do_err, do_uent_done, do_ablk_done, do_alist_done;
		logic do_after_spi;
		logic [2:0] st_step;

		byte_count_d = byte_count_q;
		declared_length_d = declared_length_q;
		phase_d = phase_q;
		remaining_d = remaining_q;
		position_d = position_q;
		high_d = high_q;
		func_d = func_q;
		version_bad_d = version_bad_q;
		error_d = error_q;
		urls_left_d = urls_left_q;
		url_num_d = url_num_q;
		auths_left_d = auths_left_q;
		auth_num_d = auth_num_q;
		auth_left_d = auth_left_q;
		step_d = step_q;
		w16 = {high_q, data_byte};
		p = position_q;
		dl = declared_length_q;
		do_adv = 1'b0;
		do_start = 1'b0;
		do_err = 1'b0;
		do_uent_done = 1'b0;
		do_ablk_done = 1'b0;
		do_alist_done = 1'b0;
		do_after_spi = 1'b0;

		case (phase_q)
			PH_HDR: begin
				position_d = p + 16'd1;
				if (p == 16'd0) begin
					if (data_byte != SLP_VERSION) begin
						version_bad_d = 1'b1;
						do_err = 1'b1;
					end
				end else if (p == 16'd1) begin
					func_d = data_byte;
					if (data_byte == 8'd0 || data_byte > 8'd7) do_err = 1'b1;
				end else if (p <= 16'd4) begin
					dl = LENGTH_BITS'({declared_length_q, data_byte});
					declared_length_d = dl;
					if (p == 16'd4 && (dl < LEN_MIN || dl >= LEN_MAX)) do_err = 1'b1;
				end else if (p == 16'd5 || p == 16'd12) begin
					high_d = data_byte;
				end else if (p == 16'd6) begin
					if ((w16 & FLAG_MASK) != 16'd0) do_err = 1'b1;
				end else if (p == 16'd13) begin
					remaining_d = w16;
					position_d = 16'd0;
					step_d = 3'd0;
					if (w16 == 16'd0) do_start = 1'b1;
					else phase_d = PH_LANG;
				end
			end
			PH_LANG: begin
				position_d = p + 16'd1;
				if (remaining_q <= 16'd1) begin
					step_d = 3'd0;
					do_start = 1'b1;
				end else remaining_d = remaining_q - 16'd1;
			end
			PH_PFX: begin
				if (p == 16'd0) begin
					high_d = data_byte;
					position_d = 16'd1;
				end else begin
					position_d = 16'd0;
					if (w16 == 16'd0) do_adv = 1'b1;
					else begin
						remaining_d = w16;
						phase_d = PH_STR;
					end
				end
			end
			PH_STR: begin
				position_d = p + 16'd1;
				if (remaining_q <= 16'd1) do_adv = 1'b1;
				else remaining_d = remaining_q - 16'd1;
			end
			PH_ERR: begin
				if (p == 16'd0) position_d = 16'd1;
				else do_adv = 1'b1;
			end
			PH_UCNT: begin
				if (p == 16'd0) begin
					high_d = data_byte;
					position_d = 16'd1;
				end else begin
					position_d = 16'd0;
					urls_left_d = w16;
					url_num_d = 16'd0;
					if (w16 == 16'd0) do_adv = 1'b1;
					else phase_d = PH_UFIX;
				end
			end
			PH_UFIX: begin
				if (p >= 16'd2) begin
					position_d = 16'd0;
					phase_d = PH_UPFX;
				end else position_d = p + 16'd1;
			end
			PH_UPFX: begin
				if (p == 16'd0) begin
					high_d = data_byte;
					position_d = 16'd1;
				end else begin
					position_d = 16'd0;
					if (w16 == 16'd0) phase_d = PH_ACNT;
					else begin
						remaining_d = w16;
						phase_d = PH_URL;
					end
				end
			end
			PH_URL: begin
				position_d = p + 16'd1;
				if (remaining_q <= 16'd1) begin
					position_d = 16'd0;
					phase_d = PH_ACNT;
				end else remaining_d = remaining_q - 16'd1;
			end
			PH_ACNT: begin
				auths_left_d = data_byte;
				auth_num_d = 8'd0;
				position_d = 16'd0;
				if (data_byte == 8'd0) do_alist_done = 1'b1;
				else phase_d = PH_AHDR;
			end
			PH_AHDR: begin
				position_d = p + 16'd1;
				if (p == 16'd2) high_d = data_byte;
				else if (p == 16'd3) begin
					if (w16 < AUTH_MIN) do_err = 1'b1;
					else auth_left_d = w16 - AUTH_MIN;
				end else if (p >= 16'd7) begin
					position_d = 16'd0;
					phase_d = PH_SPFX;
				end
			end
			PH_SPFX: begin
				if (p == 16'd0) begin
					high_d = data_byte;
					position_d = 16'd1;
				end else begin
					position_d = 16'd0;
					if (w16 > auth_left_q) do_err = 1'b1;
					else begin
						auth_left_d = auth_left_q - w16;
						if (w16 == 16'd0) do_after_spi = 1'b1;
						else begin
							remaining_d = w16;
							phase_d = PH_SPI;
						end
					end
				end
			end
			PH_SPI: begin
				position_d = p + 16'd1;
				if (remaining_q <= 16'd1) do_after_spi = 1'b1;
				else remaining_d = remaining_q - 16'd1;
			end
			PH_ADATA: begin
				position_d = p + 16'd1;
				if (auth_left_q <= 16'd1) begin
					auth_left_d = 16'd0;
					do_ablk_done = 1'b1;
				end else auth_left_d = auth_left_q - 16'd1;
			end
			PH_TRAIL: begin
				if (p != 16'hffff) position_d = p + 16'd1;
			end
			default: ;
		endcase

		// completion chain: after spi -> auth block -> auth list -> url entry
		if (do_after_spi) begin
			position_d = 16'd0;
			if (auth_left_d == 16'd0) do_ablk_done = 1'b1;
			else phase_d = PH_ADATA;
		end
		if (do_ablk_done) begin
			position_d = 16'd0;
			if (auths_left_d <= 8'd1) begin
				auths_left_d = 8'd0;
				auth_num_d = 8'd0;
				do_alist_done = 1'b1;
			end else begin
				auths_left_d = auths_left_d - 8'd1;
				auth_num_d = auth_num_d + 8'd1;
				phase_d = PH_AHDR;
			end
		end
		if (do_alist_done) begin
			if (cur_item.kind == K_UCNT || cur_item.kind == K_UENT) do_uent_done = 1'b1;
			else do_adv = 1'b1;
		end
		if (do_uent_done) begin
			position_d = 16'd0;
			if (cur_item.kind == K_UCNT && urls_left_d > 16'd1) begin
				urls_left_d = urls_left_d - 16'd1;
				url_num_d = url_num_d + 16'd1;
				phase_d = PH_UFIX;
			end else begin
				urls_left_d = 16'd0;
				do_adv = 1'b1;
			end
		end
		st_step = step_d;
		if (do_adv) begin
			st_step = step_q + 3'd1;
			step_d = st_step;
			url_num_d = 16'd0;
			do_start = 1'b1;
		end
		nit = body_item(func_d[2:0], st_step);
		if (do_start) begin
			position_d = 16'd0;
			case (nit.kind)
				K_STR: phase_d = PH_PFX;
				K_ERR: phase_d = PH_ERR;
				K_UCNT: phase_d = PH_UCNT;
				K_UENT: begin
					url_num_d = 16'd0;
					phase_d = PH_UFIX;
				end
				K_ACNT: phase_d = PH_ACNT;
				default: phase_d = PH_TRAIL;
			endcase
		end
		if (do_err) begin
			error_d = 1'b1;
			phase_d = PH_IGN;
			position_d = 16'd0;
			url_num_d = 16'd0;
			auth_num_d = 8'd0;
		end
		if (byte_count_q != LEN_MAX) byte_count_d = byte_count_q + 1'b1;

		// status on the last byte
		status_c = ST_OK;
		if (last_byte) begin
			if (version_bad_d) status_c = ST_VERSION;
			else if (error_d || phase_d != PH_TRAIL || byte_count_d != declared_length_d)
				status_c = ST_PARSE;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			declared_length_q <= '0;
			phase_q <= PH_HDR;
			remaining_q <= '0;
			position_q <= '0;
			high_q <= '0;
			func_q <= '0;
			version_bad_q <= 1'b0;
			error_q <= 1'b0;
			urls_left_q <= '0;
			url_num_q <= '0;
			auths_left_q <= '0;
			auth_num_q <= '0;
			auth_left_q <= '0;
			step_q <= '0;
		end else if (accept && last_byte) begin
			byte_count_q <= '0;
			declared_length_q <= '0;
			phase_q <= PH_HDR;
			remaining_q <= '0;
			position_q <= '0;
			high_q <= '0;
			func_q <= '0;
			version_bad_q <= 1'b0;
			error_q <= 1'b0;
			urls_left_q <= '0;
			url_num_q <= '0;
			auths_left_q <= '0;
			auth_num_q <= '0;
			auth_left_q <= '0;
			step_q <= '0;
		end else if (accept) begin
			byte_count_q <= byte_count_d;
			declared_length_q <= declared_length_d;
			phase_q <= phase_d;
			remaining_q <= remaining_d;
			position_q <= position_d;
			high_q <= high_d;
			func_q <= func_d;
			version_bad_q <= version_bad_d;
			error_q <= error_d;
			urls_left_q <= urls_left_d;
			url_num_q <= url_num_d;
			auths_left_q <= auths_left_d;
			auth_num_q <= auth_num_d;
			auth_left_q <= auth_left_d;
			step_q <= step_d;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (accept) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			field_tag <= phase_tag(phase_q);
			string_slot <= slot_c;
			field_offset <= position_q;
			entry_index <= url_num_q;
			auth_index <= auth_num_q;
			function_code <= func_d;
			done_res <= last_byte;
			status <= status_c;
		end
	end

	// checks
	`SLP_ASSERT_IMP(a_status_only_done, clk, arst_n, out_valid && !done_res, status == ST_OK)
	`SLP_ASSERT_NXT(a_last_resets, clk, arst_n, accept && last_byte, phase_q == PH_HDR && byte_count_q == '0)
	`SLP_ASSERT_IMP(a_ign_means_err, clk, arst_n, phase_q == PH_IGN, error_q)
	`SLP_ASSERT_NXT(a_stall_holds, clk, arst_n, out_valid && !out_ready, out_valid && $stable(field_offset))
endmodule
